// File: sv/lkbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkbd_pkg
// shared types and constants of the lcg keystream byte decryptor
// ----------------------------------------------------------------------------
package lkbd_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_K0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_K1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_K2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_K3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd4;

  // masks of the block update and the block boundary test
  localparam logic [15:0] MUL_PREV_MASK = 16'hFFFC;
  localparam logic [15:0] MUL_RES_MASK  = 16'hFFFD;
  localparam logic [15:0] ADD_PREV_MASK = 16'hFFFE;
  localparam logic [15:0] BLK_LAST_OFS  = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK_MUL,
    ST_BLK_ADD,
    ST_JMP_INIT,
    ST_JMP_X,
    ST_JMP_A,
    ST_JMP_M,
    ST_STEP
  } lkbd_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEEK_LOAD,  // load seeds, offset and the cipher byte
    OP_POS_INC,    // advance position, hold the cipher byte
    OP_STEP_IN,    // advance position and step on the incoming byte
    OP_STEP,       // step on the held byte
    OP_UPD_MUL,
    OP_UPD_ADD,
    OP_JMP_LOAD,
    OP_JMP_X,
    OP_JMP_A,
    OP_JMP_M
  } lkbd_op_e;

  typedef struct packed {
    lkbd_op_e op;
  } lkbd_cmd_t;

  typedef struct packed {
    logic cnt_zero;  // no block updates left in the seek
    logic n_zero;    // no jump-ahead bits left
    logic pos_wrap;  // next byte opens a new 64KiB block
  } lkbd_status_t;

endpackage

// File: sv/lkbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkbd_ctrl
// sequencer for byte steps, block updates and the seek
// ----------------------------------------------------------------------------
module lkbd_ctrl import lkbd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_start_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  lkbd_status_t status_i,
  output lkbd_cmd_t    cmd_o
);

  lkbd_state_e state_q, state_d;
  logic        seek_q, seek_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic        in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seek_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seek_q      <= seek_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    seek_d    = seek_q;
    cmd_o.op  = OP_NONE;
    out_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_start_i) begin
            cmd_o.op = OP_SEEK_LOAD;
            seek_d   = 1'b1;
            state_d  = ST_BLK_MUL;
          end else if (status_i.pos_wrap) begin
            cmd_o.op = OP_POS_INC;
            seek_d   = 1'b0;
            state_d  = ST_BLK_MUL;
          end else begin
            cmd_o.op = OP_STEP_IN;
            out_load = 1'b1;
          end
        end
      end
      ST_BLK_MUL: begin
        cmd_o.op = OP_UPD_MUL;
        state_d  = ST_BLK_ADD;
      end
      ST_BLK_ADD: begin
        cmd_o.op = OP_UPD_ADD;
        if (!seek_q) begin
          state_d = ST_STEP;
        end else if (status_i.cnt_zero) begin
          state_d = ST_JMP_INIT;
        end else begin
          state_d = ST_BLK_MUL;
        end
      end
      ST_JMP_INIT: begin
        cmd_o.op = OP_JMP_LOAD;
        state_d  = ST_JMP_X;
      end
      ST_JMP_X: begin
        if (status_i.n_zero) begin
          cmd_o.op = OP_STEP;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          cmd_o.op = OP_JMP_X;
          state_d  = ST_JMP_A;
        end
      end
      ST_JMP_A: begin
        cmd_o.op = OP_JMP_A;
        state_d  = ST_JMP_M;
      end
      ST_JMP_M: begin
        cmd_o.op = OP_JMP_M;
        state_d  = ST_JMP_X;
      end
      ST_STEP: begin
        cmd_o.op = OP_STEP;
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

endmodule

// File: sv/lkbd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkbd_dp
// seed registers, keystream state and the shared 16-bit multiply-add
// ----------------------------------------------------------------------------
module lkbd_dp import lkbd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [7:0]           cipher_byte_i,
  input  lkbd_cmd_t            cmd_i,
  output lkbd_status_t         status_o,
  output logic [7:0]           plain_byte_o
);

  logic [15:0] k0_q, k1_q, k2_q, k3_q;
  logic [31:0] offset_q;

  logic [15:0] lcg_q, lcg_d;
  logic [15:0] mul_q, mul_d;
  logic [15:0] add_q, add_d;
  logic [31:0] pos_q, pos_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] n_q, n_d;
  logic [15:0] jm_q, jm_d;
  logic [15:0] ja_q, ja_d;
  logic [7:0]  cbyte_q, cbyte_d;
  logic [7:0]  plain_q, plain_d;

  logic [15:0] mac_a, mac_b, mac_c;
  logic [31:0] mac_prod;
  logic [15:0] mac_res;
  logic [31:0] pos_inc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k0_q     <= '0;
      k1_q     <= '0;
      k2_q     <= '0;
      k3_q     <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEED_K0:      k0_q     <= cfg_data_i[15:0];
        CFG_SEED_K1:      k1_q     <= cfg_data_i[15:0];
        CFG_SEED_K2:      k2_q     <= cfg_data_i[15:0];
        CFG_SEED_K3:      k3_q     <= cfg_data_i[15:0];
        CFG_START_OFFSET: offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // keystream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= '0;
      mul_q <= '0;
      add_q <= '0;
      pos_q <= '0;
    end else begin
      lcg_q <= lcg_d;
      mul_q <= mul_d;
      add_q <= add_d;
      pos_q <= pos_d;
    end
  end

  // working registers of the seek and the result byte
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    n_q     <= n_d;
    jm_q    <= jm_d;
    ja_q    <= ja_d;
    cbyte_q <= cbyte_d;
    plain_q <= plain_d;
  end

  // shared multiply-add, low 16 bits
  always_comb begin
    mac_a = lcg_q;
    mac_b = mul_q;
    mac_c = add_q;
    case (cmd_i.op)
      OP_UPD_MUL: begin
        mac_a = k0_q;
        mac_b = mul_q & MUL_PREV_MASK;
        mac_c = {k1_q[13:0], 2'b00};
      end
      OP_UPD_ADD: begin
        mac_a = k2_q;
        mac_b = add_q & ADD_PREV_MASK;
        mac_c = {k3_q[14:0], 1'b0};
      end
      OP_JMP_X: begin
        mac_a = jm_q;
        mac_b = lcg_q;
        mac_c = ja_q;
      end
      OP_JMP_A: begin
        mac_a = ja_q;
        mac_b = 16'(jm_q + 16'd1);
        mac_c = '0;
      end
      OP_JMP_M: begin
        mac_a = jm_q;
        mac_b = jm_q;
        mac_c = '0;
      end
      default: ;
    endcase
  end

  assign mac_prod = mac_a * mac_b;
  assign mac_res  = 16'(mac_prod[15:0] + mac_c);
  assign pos_inc  = 32'(pos_q + 32'd1);

  always_comb begin
    lcg_d   = lcg_q;
    mul_d   = mul_q;
    add_d   = add_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    jm_d    = jm_q;
    ja_d    = ja_q;
    cbyte_d = cbyte_q;
    plain_d = plain_q;
    unique case (cmd_i.op)
      OP_NONE: ;
      OP_SEEK_LOAD: begin
        mul_d   = {k1_q[13:0], 2'b01};
        add_d   = {k3_q[14:0], 1'b1};
        lcg_d   = {k3_q[14:0], 1'b1};
        cnt_d   = offset_q[31:16];
        n_d     = offset_q[15:0];
        pos_d   = offset_q;
        cbyte_d = cipher_byte_i;
      end
      OP_POS_INC: begin
        pos_d   = pos_inc;
        cbyte_d = cipher_byte_i;
      end
      OP_STEP_IN: begin
        pos_d   = pos_inc;
        lcg_d   = mac_res;
        plain_d = cipher_byte_i ^ mac_res[15:8];
      end
      OP_STEP: begin
        lcg_d   = mac_res;
        plain_d = cbyte_q ^ mac_res[15:8];
      end
      OP_UPD_MUL: begin
        mul_d = (mac_res & MUL_RES_MASK) | 16'd1;
      end
      OP_UPD_ADD: begin
        add_d = mac_res | 16'd1;
        if (cnt_q != '0) begin
          cnt_d = 16'(cnt_q - 16'd1);
        end
      end
      OP_JMP_LOAD: begin
        jm_d = mul_q;
        ja_d = add_q;
      end
      OP_JMP_X: begin
        if (n_q[0]) begin
          lcg_d = mac_res;
        end
      end
      OP_JMP_A: begin
        ja_d = mac_res;
      end
      OP_JMP_M: begin
        jm_d = mac_res;
        n_d  = {1'b0, n_q[15:1]};
      end
      default: ;
    endcase
  end

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.n_zero   = (n_q == '0);
  assign status_o.pos_wrap = (pos_q[15:0] == BLK_LAST_OFS);
  assign plain_byte_o      = plain_q;

endmodule

// File: sv/lcg_keystream_byte_decryptor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_keystream_byte_decryptor
// byte stream decryptor with a 16-bit lcg keystream and offset seek
// ----------------------------------------------------------------------------
// usage
//   cfg channel: writes seed_k0..seed_k3 (index 0..3) and start_offset
//   (index 4); always ready, unknown indexes are dropped. write only while
//   the block is idle.
//   s_axis: one cipher byte per transaction, tuser set on the first byte of
//   a run, which seeks to start_offset before it is decrypted.
//   m_axis: one plain byte per input transaction, in order.
// latency and throughput
//   an ordinary byte is stepped in the cycle it is accepted and appears on
//   m_axis the next cycle; one byte per cycle while the receiver keeps up.
//   a byte that opens a new 64KiB block first runs one block update
//   (multiplier, then addend) and then the step, all through the one shared
//   16x16 multiply-add. a run-start byte runs B+1 block updates, with
//   B = start_offset[31:16], then the jump-ahead by squaring, three
//   multiply-adds per bit of start_offset[15:0] up to its highest set one.
// reset
//   seeds, offset and the keystream state all clear to zero, output empty.
// stalls
//   the result waits in the output register; a new byte is taken in the
//   same cycle the waiting one leaves, never while it is stuck.
// ----------------------------------------------------------------------------
module lcg_keystream_byte_decryptor import lkbd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] cipher_byte
  input  logic                 s_axis_tuser_i,   // [0] start_run
  // output stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o    // [7:0] plain_byte
);

  lkbd_cmd_t    cmd;
  lkbd_status_t status;
  logic         cfg_we;

  // register writes are never held off
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencer: handshakes, seek loop and jump-ahead control
  lkbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_start_i  (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: seeds, lcg state, block multiplier/addend, position
  lkbd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cipher_byte_i (s_axis_tdata_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .plain_byte_o  (m_axis_tdata_o)
  );

endmodule

// File: sv/lkbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkbd_checker
// port-level checks of the decryptor, bound to the top level
// ----------------------------------------------------------------------------
module lkbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       s_axis_tuser_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  // a stuck result blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while result is stalled");

  // a run start always seeks, and the input is held off meanwhile
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i) |=> !s_axis_tready_o)
    else $error("input ready straight after a run start");

  // result held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // result data stable while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

endmodule

bind lcg_keystream_byte_decryptor lkbd_checker u_lkbd_checker (.*);

// File: tb/sv/lkbd_keystream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkbd_keystream_checker
// watches the cfg, s_axis and m_axis channels of the lcg keystream byte
// decryptor, predicts each plain byte and compares it in order
// ----------------------------------------------------------------------------
module lkbd_keystream_checker import lkbd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] cipher_byte
  input  logic                 s_axis_tuser_i,   // [0] start_run
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [7:0]           m_axis_tdata_i,   // [7:0] plain_byte
  output int unsigned          mismatches_o,
  output int unsigned          pending_o,
  output int unsigned          bytes_o,
  output int unsigned          seeks_o,
  output int unsigned          crossings_o
);

  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned EXP_DEPTH   = 256;

  logic [15:0] seed0, seed1, seed2, seed3;
  logic [31:0] seek_offset;

  logic [15:0] ks_state, blk_mul, blk_add;
  logic [31:0] pos;

  // expected plain bytes in order, as a ring
  logic [7:0]  exp_fifo [EXP_DEPTH];
  logic [7:0]  exp_wr, exp_rd;
  int unsigned exp_cnt;

  int unsigned n_bad, n_bytes, n_seeks, n_cross, n_results;

  function automatic logic [15:0] next_multiplier(input logic [15:0] prev);
    logic [15:0] v;
    v = {seed1[13:0], 2'b00} + seed0 * (prev & MUL_PREV_MASK);
    return (v & MUL_RES_MASK) | 16'd1;
  endfunction

  function automatic logic [15:0] next_addend(input logic [15:0] prev);
    logic [15:0] v;
    v = {seed3[14:0], 1'b0} + seed2 * (prev & ADD_PREV_MASK);
    return v | 16'd1;
  endfunction

  // affine map x -> x*m + a applied n times, by squaring
  function automatic logic [15:0] leap_state(input logic [15:0] x, input logic [15:0] m,
                                             input logic [15:0] a, input logic [15:0] n);
    logic [15:0] pm, pa, rm, ra;
    int i;
    pm = m;
    pa = a;
    rm = 16'd1;
    ra = 16'd0;
    for (i = 0; i < 16; i++) begin
      if (n[i]) begin
        ra = pm * ra + pa;
        rm = pm * rm;
      end
      pa = pa * (pm + 16'd1);
      pm = pm * pm;
    end
    return rm * x + ra;
  endfunction

  function automatic logic [7:0] decrypt_next(input logic [7:0] cb, input logic restart);
    int unsigned b;
    if (restart) begin
      n_seeks++;
      blk_mul = {seed1[13:0], 2'b01};
      blk_add = {seed3[14:0], 1'b1};
      for (b = 0; b <= seek_offset[31:16]; b++) begin
        blk_mul = next_multiplier(blk_mul);
        blk_add = next_addend(blk_add);
      end
      ks_state = leap_state({seed3[14:0], 1'b1}, blk_mul, blk_add, seek_offset[15:0]);
      pos = seek_offset;
    end else begin
      pos = pos + 32'd1;
      if (pos[15:0] == 16'd0) begin
        n_cross++;
        blk_mul = next_multiplier(blk_mul);
        blk_add = next_addend(blk_add);
      end
    end
    n_bytes++;
    ks_state = ks_state * blk_mul + blk_add;
    return cb ^ ks_state[15:8];
  endfunction

  function automatic void note_failure(input string msg);
    n_bad++;
    if (n_bad <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    logic [7:0] pred;
    if (!rst_ni) begin
      seed0 = '0;
      seed1 = '0;
      seed2 = '0;
      seed3 = '0;
      seek_offset = '0;
      ks_state = '0;
      blk_mul = '0;
      blk_add = '0;
      pos = '0;
      exp_wr = '0;
      exp_rd = '0;
      exp_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SEED_K0:      seed0 = cfg_data_i[15:0];
          CFG_SEED_K1:      seed1 = cfg_data_i[15:0];
          CFG_SEED_K2:      seed2 = cfg_data_i[15:0];
          CFG_SEED_K3:      seed3 = cfg_data_i[15:0];
          CFG_START_OFFSET: seek_offset = cfg_data_i;
          default:          ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        pred = decrypt_next(s_axis_tdata_i, s_axis_tuser_i);
        if (exp_cnt == EXP_DEPTH) begin
          note_failure("too many plain bytes outstanding");
        end else begin
          exp_fifo[exp_wr] = pred;
          exp_wr = exp_wr + 8'd1;
          exp_cnt++;
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        n_results++;
        if (exp_cnt == 0) begin
          note_failure($sformatf("plain byte %02h with nothing expected (result %0d)",
                                 m_axis_tdata_i, n_results));
        end else begin
          want = exp_fifo[exp_rd];
          exp_rd = exp_rd + 8'd1;
          exp_cnt--;
          if (m_axis_tdata_i !== want) begin
            note_failure($sformatf("plain byte mismatch: expected %02h, got %02h (result %0d)",
                                   want, m_axis_tdata_i, n_results));
          end
        end
      end
    end
    mismatches_o <= n_bad;
    pending_o    <= exp_cnt;
    bytes_o      <= n_bytes;
    seeks_o      <= n_seeks;
    crossings_o  <= n_cross;
  end

endmodule

// File: tb/sv/lcg_keystream_byte_decryptor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_keystream_byte_decryptor_test
// drives cipher bytes and seed/offset settings into the decryptor, with
// random idling on both streams, and lets the checker compare every plain
// byte against its own keystream prediction
// ----------------------------------------------------------------------------
module lcg_keystream_byte_decryptor_test;
  import lkbd_pkg::*;

  // index outside the register list, must be dropped by the block
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  localparam int unsigned ITEMS        = 1750;
  localparam int unsigned QUIET_FROM   = 1500;    // no idling from here on
  localparam int unsigned HOLD_CYCLES  = 200;     // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 20;
  // the slowest seek (offset block 0xFFFF) runs the most block updates
  // without any transaction, so the limit must stay above its length
  localparam int unsigned STALL_LIMIT  = 500000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SEED_K0;
  logic [31:0]          cfg_data = '0;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;     // [7:0] cipher_byte
  logic                 s_tuser = 1'b0;   // [0] start_run

  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;          // [7:0] plain_byte

  // stimulus controls
  logic                 idle_en = 1'b1;
  logic                 hold_kick = 1'b0;   // raised once by the stimulus
  logic                 hold_done = 1'b0;   // receiver has started the hold-off
  int unsigned          hold_left = 0;
  int unsigned          gap_left = 0;
  int unsigned          quiet_cycles = 0;
  int unsigned          bytes_sent = 0;

  // checker results
  int unsigned          mismatches, pending, seen_bytes, seen_seeks, seen_crossings;

  lcg_keystream_byte_decryptor dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  lkbd_keystream_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .bytes_o         (seen_bytes),
    .seeks_o         (seen_seeks),
    .crossings_o     (seen_crossings)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // receiver: short random stalls, plus one long hold-off on request,
  // counted here so the sender keeps offering bytes meanwhile
  always @(posedge clk) begin
    if (hold_kick && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= (hold_left == 1);
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      m_tready <= (gap_left == 1);
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      gap_left <= $urandom_range(1, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog: cycles in a row without any transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d plain bytes outstanding",
               quiet_cycles, pending);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one cipher byte, with an optional idle burst in front; returns at the
  // edge of the transaction with tvalid still high
  task automatic send_byte(input logic [7:0] cb, input logic restart);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cb;
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // sender pauses until every expected plain byte has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high, the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // which[4:0] selects registers k0..k3 and start offset, which[5] adds a
  // junk write to an unused index
  task automatic program_regs(input logic [5:0] which,
                              input logic [15:0] k0, input logic [15:0] k1,
                              input logic [15:0] k2, input logic [15:0] k3,
                              input logic [31:0] ofs);
    if (which[0]) write_reg(CFG_SEED_K0, {16'd0, k0});
    if (which[1]) write_reg(CFG_SEED_K1, {16'd0, k1});
    if (which[2]) write_reg(CFG_SEED_K2, {16'd0, k2});
    if (which[3]) write_reg(CFG_SEED_K3, {16'd0, k3});
    if (which[4]) write_reg(CFG_START_OFFSET, ofs);
    if (which[5]) write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // seeds lean towards the extremes now and then
  function automatic logic [15:0] pick_seed();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // small block numbers keep the seek short; offsets just below a block
  // boundary make the following bytes cross into the next 64KiB block
  function automatic logic [31:0] pick_offset();
    logic [15:0] blk, ofs;
    blk = 16'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       ofs = 16'($urandom_range(0, 65535));
      1:       ofs = 16'($urandom_range(0, 7));
      default: ofs = 16'hFFFF - 16'($urandom_range(0, 40));
    endcase
    return {blk, ofs};
  endfunction

  initial begin : stimulus
    int unsigned run_len;
    int unsigned phase;
    logic [5:0]  which;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes before any run start use the all-zero reset state
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    wait_drained();

    // all-zero seeds, offset zero: no jump-ahead at all
    program_regs(6'h1F, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    wait_drained();

    // all-ones seeds, full 16-bit jump, then a block crossing
    program_regs(6'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_FFFF);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b0);
    wait_drained();

    // largest offset: long seek, then the position wraps to zero
    program_regs(6'h1F, pick_seed(), pick_seed(), pick_seed(), pick_seed(), 32'hFFFF_FFFF);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();

    // offset on a block boundary, with a write to an unused index
    program_regs(6'h3F, pick_seed(), pick_seed(), pick_seed(), pick_seed(), 32'h0001_0000);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();

    // seeds changed in the middle of a run, the next crossing uses them
    program_regs(6'h1F, pick_seed(), pick_seed(), pick_seed(), pick_seed(), 32'h0002_FFFE);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();
    program_regs(6'h05, 16'($urandom_range(0, 65535)), 16'h0000,
                 16'($urandom_range(0, 65535)), 16'h0000, 32'h0000_0000);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);

    // random runs: mostly a seek followed by plain bytes, some runs carry
    // on from the last position, and a few stray run starts mid-stream
    phase = 0;
    while (bytes_sent < ITEMS) begin
      wait_drained();
      if (bytes_sent >= QUIET_FROM) idle_en <= 1'b0;
      if (phase % 8 == 0) which = 6'h3F;
      else                which = 6'($urandom_range(0, 63));
      program_regs(which, pick_seed(), pick_seed(), pick_seed(), pick_seed(), pick_offset());
      run_len = $urandom_range(0, 40);
      if (phase == 6) begin
        // output held off while bytes keep coming, block must back up
        hold_kick <= 1'b1;
        run_len = 30;
      end
      if (phase == 6 || $urandom_range(0, 5) != 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      repeat (run_len) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 40) == 0);
      phase++;
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d cipher bytes, %0d run starts with seek, %0d 64KiB block crossings",
             seen_bytes, seen_seeks, seen_crossings);
    $display("settings incl. all-zero and all-ones seeds, largest offset and position wrap");
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d plain bytes outstanding", mismatches, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
